>>> sv/mcnp_pkg.sv
// Shared types, constants and keyword tables for the chunk name parser.
// No dependencies; every other file imports this package.
`default_nettype none

package mcnp_pkg;

    localparam int KW_COUNT    = 7;
    localparam int KW_VTT      = 0;
    localparam int KW_INIT     = 1;
    localparam int KW_MP4      = 2;
    localparam int KW_FRAGMENT = 3;
    localparam int KW_M4S      = 4;
    localparam int KW_SEG      = 5;
    localparam int KW_TS       = 6;

    localparam logic [3:0]  LEN_SAT   = 4'd9;
    localparam logic [1:0]  POS_SAT   = 2'd2;
    localparam logic [63:0] ACC_LIMIT = 64'd1844674407370955161;

    localparam logic [7:0] CHR_DASH = 8'h2D;
    localparam logic [7:0] CHR_DOT  = 8'h2E;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;
    localparam logic [7:0] CHR_V    = 8'h76;
    localparam logic [7:0] CHR_A    = 8'h61;
    localparam logic [7:0] CHR_P    = 8'h70;
    localparam logic [7:0] CHR_S    = 8'h73;
    localparam logic [7:0] CHR_F    = 8'h66;
    localparam logic [7:0] CHR_X    = 8'h78;

    localparam logic [1:0] CONT_MP4 = 2'd0;
    localparam logic [1:0] CONT_TS  = 2'd1;
    localparam logic [1:0] CONT_VTT = 2'd2;

    localparam int FLAG_V     = 0;
    localparam int FLAG_A     = 1;
    localparam int FLAG_P     = 2;
    localparam int FLAG_S     = 3;
    localparam int FLAG_S_ONE = 4;

    typedef enum logic [1:0] {
        WK_UNKNOWN  = 2'd0,
        WK_INIT     = 2'd1,
        WK_SEG      = 2'd2,
        WK_FRAGMENT = 2'd3
    } mcnp_word_kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } mcnp_item_t;

    typedef struct packed {
        logic        name_valid;
        logic [1:0]  container_kind;
        logic        is_init_chunk;
        logic [63:0] chunk_number;
        logic        video_present;
        logic [31:0] video_track;
        logic        audio_present;
        logic [31:0] audio_track;
        logic        part_present;
        logic [31:0] part_number;
        logic        subtitle_present;
    } mcnp_result_t;

    // Per-token scratch state, cleared at every separator
    typedef struct packed {
        logic [3:0]          len;
        logic [KW_COUNT-1:0] cand;
        logic [7:0]          key;
        logic [63:0]         acc;
        logic                ovf;
        logic                nondig;
    } mcnp_token_t;

    localparam mcnp_token_t TOKEN_CLEAR = '{
        len:    4'd0,
        cand:   {KW_COUNT{1'b1}},
        key:    8'd0,
        acc:    64'd0,
        ovf:    1'b0,
        nondig: 1'b0
    };

    function automatic logic [3:0] kw_len(input int k);
        logic [3:0] n;
        case (k)
            KW_VTT:      n = 4'd3;
            KW_INIT:     n = 4'd4;
            KW_MP4:      n = 4'd3;
            KW_FRAGMENT: n = 4'd8;
            KW_M4S:      n = 4'd3;
            KW_SEG:      n = 4'd3;
            KW_TS:       n = 4'd2;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    // Keyword text, left-justified in 64 bits
    function automatic logic [63:0] kw_word(input int k);
        logic [63:0] w;
        case (k)
            KW_VTT:      w = {"vtt", 40'd0};
            KW_INIT:     w = {"init", 32'd0};
            KW_MP4:      w = {"mp4", 40'd0};
            KW_FRAGMENT: w = "fragment";
            KW_M4S:      w = {"m4s", 40'd0};
            KW_SEG:      w = {"seg", 40'd0};
            KW_TS:       w = {"ts", 48'd0};
            default:     w = 64'd0;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] idx);
        logic [63:0] shifted;
        shifted = kw_word(k) << {idx, 3'b000};
        return shifted[63:56];
    endfunction

    function automatic logic [KW_COUNT-1:0] kw_match_vec(
        input logic [KW_COUNT-1:0] cand,
        input logic [3:0]          len
    );
        logic [KW_COUNT-1:0] m;
        for (int k = 0; k < KW_COUNT; k++) begin
            m[k] = cand[k] && (len == kw_len(k));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> sv/media_chunk_name_parser.sv
// Top level of the chunk name parser: input register, parse core, result register.
// Depends on mcnp_pkg and mcnp_parse_core.
`default_nettype none

// Segment file names enter one byte per item, last_byte set on the final
// character; exactly one result item comes out per name, with result_valid
// registered when the parse stage takes its final byte. The block takes
// one byte every cycle: each byte passes the input register, then a single
// pass through the keyword filter and the multiply-by-ten accumulator into
// the name state. The only stall is a final byte reaching the parse stage
// while the previous result is still unread.
module media_chunk_name_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  mcnp_pkg::mcnp_item_t   item,
    output logic                   result_valid,
    input  logic                   result_ready,
    output mcnp_pkg::mcnp_result_t result
);
    import mcnp_pkg::*;

    logic         item_valid_reg;
    mcnp_item_t   item_reg;
    logic         result_valid_reg;
    mcnp_result_t result_reg;
    mcnp_result_t result_next;
    logic         hold;
    logic         advance;

    // a final byte waits while the result register is still occupied
    assign hold       = item_valid_reg && item_reg.last_byte && result_valid_reg && !result_ready;
    assign advance    = item_valid_reg && !hold;
    assign item_ready = !hold;

    mcnp_parse_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && item_reg.last_byte)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_reg.last_byte)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

>>> sv/mcnp_token_unit.sv
// Per-byte token update: keyword candidate filter, key letter capture and
// decimal accumulate with overflow detection. Depends on mcnp_pkg.
`default_nettype none

module mcnp_token_unit (
    input  mcnp_pkg::mcnp_token_t tok,
    input  logic [7:0]            text_byte,
    input  logic                  index_mode,
    output mcnp_pkg::mcnp_token_t tok_upd
);
    import mcnp_pkg::*;

    logic        is_digit;
    logic [3:0]  digit;
    logic [63:0] acc_x10;
    logic        ovf_step;

    assign is_digit = (text_byte >= CHR_ZERO) && (text_byte <= CHR_NINE);
    assign digit    = text_byte[3:0];
    assign acc_x10  = {tok.acc[60:0], 3'b000} + {tok.acc[62:0], 1'b0};
    assign ovf_step = (tok.acc > ACC_LIMIT) || ((tok.acc == ACC_LIMIT) && (digit > 4'd5));

    always_comb
    begin
        tok_upd = tok;
        for (int k = 0; k < KW_COUNT; k++) begin
            tok_upd.cand[k] = tok.cand[k] && (tok.len < kw_len(k))
                              && (kw_char(k, tok.len[2:0]) == text_byte);
        end
        // first byte of a key token is its letter; everything else must be a digit, else nondig is set
        if (!index_mode && (tok.len == 4'd0))
        begin
            tok_upd.key = text_byte;
        end
        else if (!is_digit)
        begin
            tok_upd.nondig = 1'b1;
        end
        else
        begin
            if (ovf_step)
            begin
                tok_upd.ovf = 1'b1;
            end
            tok_upd.acc = acc_x10 + {60'd0, digit};
        end
        if (tok.len < LEN_SAT)
        begin
            tok_upd.len = tok.len + 4'd1;
        end
    end

endmodule

`default_nettype wire

>>> sv/mcnp_parse_core.sv
// Name state registers, token close-out and final checks for one item a cycle while step is high.
// Depends on mcnp_pkg and mcnp_token_unit.
`default_nettype none

module mcnp_parse_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  mcnp_pkg::mcnp_item_t   item,
    output mcnp_pkg::mcnp_result_t result
);
    import mcnp_pkg::*;

    logic            error_reg, error_next;
    logic [1:0]      pos_reg, pos_next;
    mcnp_word_kind_t kind_reg, kind_next;
    mcnp_token_t     tok_reg, tok_next, tok_upd;
    logic [63:0]     index_reg, index_next;
    logic [31:0]     video_reg, video_next;
    logic [31:0]     audio_reg, audio_next;
    logic [31:0]     part_reg, part_next;
    logic [4:0]      flags_reg, flags_next;

    logic                is_sep;
    logic                index_mode;
    logic [KW_COUNT-1:0] match_cur;
    logic [KW_COUNT-1:0] match_end;
    logic                ok;
    logic [1:0]          cont;
    logic                init;

    assign is_sep     = (item.text_byte == CHR_DASH) || (item.text_byte == CHR_DOT);
    assign index_mode = (pos_reg == 2'd1) && ((kind_reg == WK_SEG) || (kind_reg == WK_FRAGMENT));
    assign match_cur  = kw_match_vec(tok_reg.cand, tok_reg.len);

    mcnp_token_unit u_token (
        .tok        (tok_reg),
        .text_byte  (item.text_byte),
        .index_mode (index_mode),
        .tok_upd    (tok_upd)
    );

    always_comb
    begin
        error_next = error_reg;
        pos_next   = pos_reg;
        kind_next  = kind_reg;
        index_next = index_reg;
        video_next = video_reg;
        audio_next = audio_reg;
        part_next  = part_reg;
        flags_next = flags_reg;
        tok_next   = tok_upd;

        if (is_sep)
        begin
            if (pos_reg == 2'd0)
            begin
                if (match_cur[KW_INIT])
                    kind_next = WK_INIT;
                else if (match_cur[KW_SEG])
                    kind_next = WK_SEG;
                else if (match_cur[KW_FRAGMENT])
                    kind_next = WK_FRAGMENT;
                else
                    kind_next = WK_UNKNOWN;
            end
            else if (index_mode)
            begin
                if ((tok_reg.len == 4'd0) || tok_reg.nondig || tok_reg.ovf
                    || (tok_reg.acc == 64'd0))
                    error_next = 1'b1;
                else
                    index_next = tok_reg.acc;
            end
            else if ((tok_reg.len < 4'd2) || tok_reg.nondig || tok_reg.ovf
                     || (tok_reg.acc[63:32] != 32'd0))
            begin
                error_next = 1'b1;
            end
            else
            begin
                case (tok_reg.key) inside
                    CHR_V:
                    begin
                        video_next         = tok_reg.acc[31:0];
                        flags_next[FLAG_V] = 1'b1;
                    end
                    CHR_A:
                    begin
                        audio_next         = tok_reg.acc[31:0];
                        flags_next[FLAG_A] = 1'b1;
                    end
                    CHR_P:
                    begin
                        part_next          = tok_reg.acc[31:0];
                        flags_next[FLAG_P] = 1'b1;
                    end
                    CHR_S:
                    begin
                        flags_next[FLAG_S]     = 1'b1;
                        flags_next[FLAG_S_ONE] = (tok_reg.acc[31:0] == 32'd1);
                    end
                    CHR_F, CHR_X:
                    begin
                        error_next = error_reg;
                    end
                    default:
                    begin
                        error_next = 1'b1;
                    end
                endcase
            end
            if (pos_reg != POS_SAT)
            begin
                pos_next = pos_reg + 2'd1;
            end
            tok_next = TOKEN_CLEAR;
        end

        // final checks see the state after this byte
        match_end = kw_match_vec(tok_next.cand, tok_next.len);
        ok        = !error_next && (pos_next == POS_SAT);
        cont      = CONT_MP4;
        init      = 1'b0;
        if (match_end[KW_VTT])
        begin
            ok   = ok && ((kind_next == WK_SEG) || (kind_next == WK_FRAGMENT));
            cont = CONT_VTT;
        end
        else if (kind_next == WK_INIT)
        begin
            ok   = ok && match_end[KW_MP4];
            init = 1'b1;
        end
        else if (kind_next == WK_FRAGMENT)
        begin
            ok = ok && match_end[KW_M4S];
        end
        else if (kind_next == WK_SEG)
        begin
            ok   = ok && match_end[KW_TS];
            cont = CONT_TS;
        end
        else
        begin
            ok = 1'b0;
        end
        if (flags_next[FLAG_V] && (video_next == 32'd0))
            ok = 1'b0;
        if (flags_next[FLAG_A] && (audio_next == 32'd0))
            ok = 1'b0;
        if (flags_next[FLAG_S] && !flags_next[FLAG_S_ONE])
            ok = 1'b0;

        result = '0;
        if (ok)
        begin
            result.name_valid       = 1'b1;
            result.container_kind   = cont;
            result.is_init_chunk    = init;
            result.chunk_number     = init ? 64'd0 : index_next;
            result.video_present    = flags_next[FLAG_V];
            result.video_track      = flags_next[FLAG_V] ? video_next : 32'd0;
            result.audio_present    = flags_next[FLAG_A];
            result.audio_track      = flags_next[FLAG_A] ? audio_next : 32'd0;
            result.part_present     = flags_next[FLAG_P];
            result.part_number      = flags_next[FLAG_P] ? part_next : 32'd0;
            result.subtitle_present = flags_next[FLAG_S];
        end

        // drop all name state after the final byte
        if (item.last_byte)
        begin
            error_next = 1'b0;
            pos_next   = 2'd0;
            kind_next  = WK_UNKNOWN;
            index_next = 64'd0;
            video_next = 32'd0;
            audio_next = 32'd0;
            part_next  = 32'd0;
            flags_next = 5'd0;
            tok_next   = TOKEN_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_reg <= 1'b0;
            pos_reg   <= 2'd0;
            kind_reg  <= WK_UNKNOWN;
            tok_reg   <= TOKEN_CLEAR;
            index_reg <= 64'd0;
            video_reg <= 32'd0;
            audio_reg <= 32'd0;
            part_reg  <= 32'd0;
            flags_reg <= 5'd0;
        end
        else if (step)
        begin
            error_reg <= error_next;
            pos_reg   <= pos_next;
            kind_reg  <= kind_next;
            tok_reg   <= tok_next;
            index_reg <= index_next;
            video_reg <= video_next;
            audio_reg <= audio_next;
            part_reg  <= part_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/mcnp_checker.sv
// Port-level checks for the chunk name parser, bound to the top level.
// Depends on mcnp_pkg and media_chunk_name_parser.
`default_nettype none

module mcnp_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  mcnp_pkg::mcnp_result_t result
);
    import mcnp_pkg::*;

    logic rest_zero;

    assign rest_zero = (result.container_kind == CONT_MP4) && !result.is_init_chunk
                       && (result.chunk_number == 64'd0) && !result.video_present
                       && (result.video_track == 32'd0) && !result.audio_present
                       && (result.audio_track == 32'd0) && !result.part_present
                       && (result.part_number == 32'd0) && !result.subtitle_present;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result item dropped before it was taken");

    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result item changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.name_valid |-> rest_zero)
        else $error("rejected name carries nonzero fields");

    a_init_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.name_valid && result.is_init_chunk
        |-> (result.chunk_number == 64'd0) && (result.container_kind == CONT_MP4))
        else $error("init chunk with index or wrong container");

    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.name_valid && !result.is_init_chunk
        |-> (result.chunk_number != 64'd0) && (result.container_kind <= CONT_VTT))
        else $error("media chunk with zero index or bad container");

endmodule

bind media_chunk_name_parser mcnp_checker u_mcnp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
